>>> src/sike_pkg.sv
// Shared constants and types for the sortable index key encoder.
// No dependencies; used by sike_encode and sortable_index_key_encoder.
package sike_pkg;

  // Key capacity and derived widths
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_LEN_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int SEG_BYTES     = 8;
  localparam int SEG_W         = SEG_BYTES * 8;
  localparam int CNT_W         = $clog2(SEG_BYTES + 1);
  localparam int POS_W         = 8;
  localparam int REC_W         = 31;
  localparam int MODE_W        = 2;

  // Mode codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_NUMBER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Double pattern sign handling
  localparam logic [SEG_W-1:0] SIGN_MASK = 64'h8000_0000_0000_0000;

  // Record number code lengths (bytes), also the nibble stored at both ends
  localparam logic [3:0] REC_LEN_2 = 4'd2;
  localparam logic [3:0] REC_LEN_3 = 4'd3;
  localparam logic [3:0] REC_LEN_4 = 4'd4;
  localparam logic [3:0] REC_LEN_5 = 4'd5;

  // One encoded segment: bytes left-aligned, most significant first
  typedef struct packed {
    logic [SEG_W-1:0] bytes;
    logic [CNT_W-1:0] cnt;    // zero means no segment
  } seg_info_t;

endpackage

>>> src/sike_encode.sv
// Segment encoder: turns one input item into left-aligned key bytes and a count.
// Depends on sike_pkg.
module sike_encode (
  input  logic [sike_pkg::MODE_W-1:0] mode,
  input  logic [sike_pkg::SEG_W-1:0]  number_bits,
  input  logic [sike_pkg::REC_W-1:0]  record_number,
  output sike_pkg::seg_info_t         seg
);
  import sike_pkg::*;

  logic [SEG_W-1:0] num_v;
  logic [CNT_W-1:0] num_cnt;
  logic [SEG_W-1:0] rec_v;
  logic [CNT_W-1:0] rec_cnt;

  // Number: flip sign of non-negative, invert negative, drop trailing zero bytes
  always_comb begin
    num_v   = number_bits[SEG_W-1] ? ~number_bits : (number_bits ^ SIGN_MASK);
    num_cnt = '0;
    for (int i = 0; i < SEG_BYTES; i++) begin
      if (num_v[SEG_W-1-8*i -: 8] != 8'h00) begin
        num_cnt = CNT_W'(i + 1);
      end
    end
  end

  // Record number: length nibble, big-endian value, length nibble
  always_comb begin
    if (record_number[REC_W-1:8] == '0) begin
      rec_v   = {REC_LEN_2, record_number[7:0], REC_LEN_2, 48'h0};
      rec_cnt = CNT_W'(REC_LEN_2);
    end else if (record_number[REC_W-1:16] == '0) begin
      rec_v   = {REC_LEN_3, record_number[15:0], REC_LEN_3, 40'h0};
      rec_cnt = CNT_W'(REC_LEN_3);
    end else if (record_number[REC_W-1:24] == '0) begin
      rec_v   = {REC_LEN_4, record_number[23:0], REC_LEN_4, 32'h0};
      rec_cnt = CNT_W'(REC_LEN_4);
    end else begin
      rec_v   = {REC_LEN_5, 1'b0, record_number, REC_LEN_5, 24'h0};
      rec_cnt = CNT_W'(REC_LEN_5);
    end
  end

  // Mode select; clear and the unused code give no segment
  always_comb begin
    case (mode)
      MODE_NUMBER: begin
        seg.bytes = num_v;
        seg.cnt   = num_cnt;
      end
      MODE_RECORD: begin
        seg.bytes = rec_v;
        seg.cnt   = rec_cnt;
      end
      default: begin
        seg.bytes = '0;
        seg.cnt   = '0;
      end
    endcase
  end

endmodule

>>> src/sortable_index_key_encoder.sv
// Sortable index key encoder top level: input register, segment serializer, output register.
// Depends on sike_pkg and sike_encode.
//
// Each input transfer appends one segment to a bytewise-comparable key and the
// segment's bytes leave one per output transfer, most significant first. A number
// segment gives 1 to 8 bytes, a record number segment 2 to 5 bytes; a segment that
// does not fit gives a single zero byte with tuser (overflow) and tlast set, and the
// key is left as it was. Clear, the unused mode and an all-zero number segment give
// no output. The output register is byte-wide: an item occupies the serializer
// until all of its bytes have left, one per output transfer. The first output byte
// passes through the input register and the serializer to the output register.
// The input register can take one item while the serializer and output register
// still hold earlier work; an item that makes a segment then waits there until
// the serializer is free, while clear, unused-mode and empty items move on at once.
module sortable_index_key_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [63:0] number_bits, [94:64] record_number, [95] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [15:8] byte_position
  output logic        out_tlast,  // last byte of the segment
  output logic [0:0]  out_tuser   // [0] overflow
);
  import sike_pkg::*;

  // Input register
  logic                 in_valid_r;
  logic [MODE_W-1:0]    in_mode_r;
  logic [SEG_W-1:0]     in_bits_r;
  logic [REC_W-1:0]     in_rec_r;

  // Segment serializer
  logic                 seg_valid_r;
  logic [SEG_W-1:0]     seg_bytes_r;
  logic [CNT_W-1:0]     seg_cnt_r;
  logic [POS_W-1:0]     seg_pos_r;
  logic                 seg_ovf_r;

  // Output register
  logic                 out_tvalid_r;
  logic [15:0]          out_tdata_r;
  logic                 out_tlast_r;
  logic                 out_ovf_r;

  // Running key length
  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] key_len_nxt;

  seg_info_t            enc;
  logic [KEY_LEN_W:0]   len_sum;
  logic                 fits;
  logic                 out_free;
  logic                 emit;
  logic                 seg_done;
  logic                 seg_free;
  logic                 in_take;
  logic                 seg_load;

  sike_encode u_encode (
    .mode          (in_mode_r),
    .number_bits   (in_bits_r),
    .record_number (in_rec_r),
    .seg           (enc)
  );

  // Handshake and stage control
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit      = seg_valid_r && out_free;
  assign seg_done  = emit && (seg_cnt_r == CNT_W'(1));
  assign seg_free  = !seg_valid_r || seg_done;
  assign in_take   = in_valid_r && ((enc.cnt == '0) || seg_free);
  assign seg_load  = in_take && (enc.cnt != '0);
  assign in_tready = !in_valid_r || in_take;

  // Capacity check
  assign len_sum = {1'b0, key_len_r} + (KEY_LEN_W+1)'(enc.cnt);
  assign fits    = len_sum <= (KEY_LEN_W+1)'(MAX_KEY_BYTES);

  // Key length update
  always_comb begin
    key_len_nxt = key_len_r;
    if (in_take && (in_mode_r == MODE_CLEAR)) begin
      key_len_nxt = '0;
    end else if (seg_load && fits) begin
      key_len_nxt = len_sum[KEY_LEN_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      seg_valid_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      key_len_r    <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (seg_load) begin
        seg_valid_r <= 1'b1;
      end else if (seg_done) begin
        seg_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_tvalid_r <= emit;
      end
      key_len_r <= key_len_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r <= in_tuser;
      in_bits_r <= in_tdata[63:0];
      in_rec_r  <= in_tdata[94:64];
    end
    if (seg_load) begin
      seg_pos_r <= POS_W'(key_len_r);
      if (fits) begin
        seg_bytes_r <= enc.bytes;
        seg_cnt_r   <= enc.cnt;
        seg_ovf_r   <= 1'b0;
      end else begin
        seg_bytes_r <= '0;
        seg_cnt_r   <= CNT_W'(1);
        seg_ovf_r   <= 1'b1;
      end
    end else if (emit) begin
      seg_bytes_r <= {seg_bytes_r[SEG_W-9:0], 8'h00};
      seg_cnt_r   <= seg_cnt_r - CNT_W'(1);
      seg_pos_r   <= seg_pos_r + POS_W'(1);
    end
    if (emit) begin
      out_tdata_r <= {seg_pos_r, seg_bytes_r[SEG_W-1 -: 8]};
      out_tlast_r <= (seg_cnt_r == CNT_W'(1));
      out_ovf_r   <= seg_ovf_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tlast    = out_tlast_r;
  assign out_tuser[0] = out_ovf_r;

`ifndef SYNTHESIS
  // Key never grows past capacity
  a_key_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= KEY_LEN_W'(MAX_KEY_BYTES))
    else $error("key length above capacity");

  // A busy serializer always has bytes left
  a_seg_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid_r |-> (seg_cnt_r != '0) && (seg_cnt_r <= CNT_W'(SEG_BYTES)))
    else $error("serializer busy with no bytes");

  // Overflow result is a lone zero byte closing its segment
  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata[7:0] == 8'h00)))
    else $error("malformed overflow result");

  // A segment that overflowed leaves the key length alone
  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_load && !fits) |=> (key_len_r == $past(key_len_r)))
    else $error("key length changed on overflow");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for sortable_index_key_encoder.
// Depends on sike_pkg and the encoder RTL. Directed and random segments are
// predicted per transfer and every output byte is compared in order.
`timescale 1ns / 100ps

module tb;
  import sike_pkg::*;

  // Mode code that the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] kbyte;
    logic [7:0] pos;
    logic       last;
    logic       ovf;
  } key_byte_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // [63:0] number_bits, [94:64] record_number, [95] zero
  logic [1:0]  in_tuser   = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] out_byte, [15:8] byte_position
  logic        out_tlast;
  logic [0:0]  out_tuser;         // [0] overflow

  // Predictor state and bookkeeping
  key_byte_t expected_key_bytes[$];
  int        key_len       = 0;
  int        tx_idle_pct   = 0;
  int        rx_stall_pct  = 0;
  int        mismatches    = 0;
  int        bytes_checked = 0;
  int        overflows     = 0;
  int        mode_count[4] = '{0, 0, 0, 0};

  sortable_index_key_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Compute the segment for one accepted transfer and queue its bytes
  task automatic predict_key_bytes(input logic [1:0] mode, input logic [63:0] bits,
                                   input logic [30:0] rec);
    logic [7:0]  seg [8];
    logic [63:0] v;
    int          n;
    int          len;
    int          sh;
    key_byte_t   kb;
    n = 0;
    case (mode)
      MODE_NUMBER: begin
        // non-negative: set sign; negative: invert everything
        v = bits[63] ? ~bits : (bits ^ SIGN_MASK);
        for (int i = 0; i < 8; i++) seg[i] = v[63 - 8 * i -: 8];
        n = 8;
        while (n > 0 && seg[n - 1] == 8'd0) n--;
      end
      MODE_RECORD: begin
        if (rec < 31'd256) len = 2;
        else if (rec < 31'd65536) len = 3;
        else if (rec < 31'd16777216) len = 4;
        else len = 5;
        // length nibble leads, then record bits big-endian, length nibble trails
        sh = len * 8 - 12;
        seg[0] = {4'(len), 4'(rec >> sh)};
        n = 1;
        for (sh = sh - 8; sh > 0; sh -= 8) begin
          seg[n] = 8'(rec >> sh);
          n++;
        end
        seg[n] = {rec[3:0], 4'(len)};
        n++;
      end
      MODE_CLEAR: key_len = 0;
      default: ;
    endcase
    if (n == 0) return;
    if (key_len + n > MAX_KEY_BYTES) begin
      kb = '{kbyte: 8'd0, pos: 8'(key_len), last: 1'b1, ovf: 1'b1};
      expected_key_bytes.push_back(kb);
      overflows++;
      return;
    end
    for (int i = 0; i < n; i++) begin
      kb = '{kbyte: seg[i], pos: 8'(key_len + i), last: (i == n - 1), ovf: 1'b0};
      expected_key_bytes.push_back(kb);
    end
    key_len += n;
  endtask

  // Present one item at the falling edge and hold it until the transfer
  task automatic send_key_item(input logic [1:0] mode, input logic [63:0] bits,
                               input logic [30:0] rec);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, rec, bits};
    do @(posedge clk); while (!in_tready);
    predict_key_bytes(mode, bits, rec);
    mode_count[mode]++;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Random receiver stalls, changed at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Output checker
  always @(posedge clk) begin
    key_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (expected_key_bytes.size() == 0) begin
        report_mismatch("unexpected output", out_tdata, 16'd0);
      end else begin
        want = expected_key_bytes.pop_front();
        if (out_tdata[7:0] !== want.kbyte)
          report_mismatch("out_byte", 16'(out_tdata[7:0]), 16'(want.kbyte));
        if (out_tdata[15:8] !== want.pos)
          report_mismatch("byte_position", 16'(out_tdata[15:8]), 16'(want.pos));
        if (out_tlast !== want.last)
          report_mismatch("tlast", 16'(out_tlast), 16'(want.last));
        if (out_tuser[0] !== want.ovf)
          report_mismatch("overflow", 16'(out_tuser[0]), 16'(want.ovf));
      end
    end
  end

  function automatic logic [63:0] random_bits64();
    return {$urandom, $urandom};
  endfunction

  // Record number with a code of the given length (2 to 5 bytes)
  function automatic logic [30:0] random_record(input int len);
    case (len)
      2:       return 31'($urandom_range(255, 0));
      3:       return 31'($urandom_range(65535, 256));
      4:       return 31'($urandom_range(16777215, 65536));
      default: return 31'($urandom_range(32'h7fff_ffff, 16777216));
    endcase
  endfunction

  // Signed zeros, infinities, the all-ones pattern and every segment length
  task automatic test_numbers();
    send_key_item(MODE_NUMBER, 64'h0000_0000_0000_0000, random_record(5));
    send_key_item(MODE_NUMBER, 64'h8000_0000_0000_0000, random_record(5));
    send_key_item(MODE_NUMBER, 64'hffff_ffff_ffff_ffff, random_record(2));  // empty segment
    send_key_item(MODE_NUMBER, 64'h7fff_ffff_ffff_ffff, '0);
    send_key_item(MODE_NUMBER, 64'hfff0_0000_0000_0000, '1);
    send_key_item(MODE_NUMBER, 64'h7ff0_0000_0000_0000, '0);
    send_key_item(MODE_NUMBER, 64'hbff0_0000_0000_0000, '1);
    // positive value trimmed to 8 down to 1 bytes
    for (int k = 0; k < 8; k++)
      send_key_item(MODE_NUMBER, 64'h3ff1_2345_6789_abcd & ~((64'd1 << (8 * k)) - 64'd1), '0);
  endtask

  // Range boundaries of the record code lengths
  task automatic test_records();
    logic [30:0] edges [8];
    edges = '{31'd0, 31'd255, 31'd256, 31'd65535, 31'd65536,
              31'd16777215, 31'd16777216, 31'h7fff_ffff};
    foreach (edges[i]) send_key_item(MODE_RECORD, random_bits64(), edges[i]);
  endtask

  task automatic test_clear_and_unused();
    send_key_item(MODE_UNUSED, random_bits64(), random_record(5));
    send_key_item(MODE_CLEAR, random_bits64(), random_record(4));
    send_key_item(MODE_NUMBER, 64'h4009_21fb_5444_2d18, '0);  // lands at offset 0
  endtask

  // Fill the key to its limit, both exactly and one short, then overflow
  task automatic test_key_capacity();
    logic [63:0] bits;
    for (int pass = 0; pass < 2; pass++) begin
      send_key_item(MODE_CLEAR, '0, '0);
      for (int i = 0; i < 31; i++) begin
        bits = random_bits64();
        send_key_item(MODE_NUMBER, {1'b0, bits[62:1], 1'b1}, random_record(3));
      end
      if (pass == 0) begin
        send_key_item(MODE_RECORD, random_bits64(), random_record(5));  // 253
        send_key_item(MODE_RECORD, random_bits64(), random_record(3));  // 256, full
      end else begin
        send_key_item(MODE_RECORD, random_bits64(), random_record(4));  // 252
        send_key_item(MODE_RECORD, random_bits64(), random_record(3));  // 255
      end
      send_key_item(MODE_RECORD, random_bits64(), random_record(2));    // overflow
      send_key_item(MODE_NUMBER, 64'd0, '0);                            // one byte
      send_key_item(MODE_NUMBER, 64'd0, '0);
    end
    send_key_item(MODE_CLEAR, random_bits64(), '0);
  endtask

  // Mostly appends with random trailing zero bytes, rare clears and unused codes
  task automatic test_random_keys(input int count, input int tx_pct, input int rx_pct);
    logic [63:0] bits;
    logic [63:0] low_mask;
    int          pick;
    int          k;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      bits = random_bits64();
      if (pick < 2) begin
        send_key_item(MODE_CLEAR, bits, 31'($urandom));
      end else if (pick < 5) begin
        send_key_item(MODE_UNUSED, bits, 31'($urandom));
      end else if (pick < 55) begin
        // force the low k bytes so that the segment ends k bytes early
        k = $urandom_range(8);
        low_mask = (64'd1 << (8 * k)) - 64'd1;
        if (bits[63]) bits = bits | low_mask;
        else bits = bits & ~low_mask;
        send_key_item(MODE_NUMBER, bits, 31'($urandom));
      end else begin
        send_key_item(MODE_RECORD, bits, random_record($urandom_range(5, 2)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_numbers();
    test_records();
    test_clear_and_unused();
    test_key_capacity();
    test_random_keys(70, 0, 0);
    test_random_keys(65, 75, 0);
    test_random_keys(65, 0, 75);
    test_random_keys(65, 11, 11);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_key_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d items: %0d number, %0d record, %0d clear, %0d unused mode",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("Checked %0d key bytes, %0d of them overflow results", bytes_checked, overflows);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
